### src/hcd_pkg.sv
package hcd_pkg;

    localparam int SIZE_BITS = 32;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        PH_SIZE = 5'b00001,
        PH_LF   = 5'b00010,
        PH_DATA = 5'b00100,
        PH_END  = 5'b01000,
        PH_ERR  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        kind_t      kind;
    } hcd_result_t;

    typedef struct packed {
        logic        valid;
        hcd_result_t res;
    } hcd_push_t;

    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

endpackage

### src/hcd_front.sv
module hcd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              q_full,
    output hcd_pkg::hcd_push_t push
);
    import hcd_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic                 saw_reg, saw_next;
    logic                 accept;
    logic [4:0]           hv;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign hv       = hex_decode(s_tdata);

    always_comb
    begin
        phase_next            = phase_reg;
        size_next             = size_reg;
        rem_next              = rem_reg;
        saw_next              = saw_reg;
        push.valid            = 1'b0;
        push.res.payload_byte = 8'd0;
        push.res.kind         = KIND_DATA;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SIZE:
                begin
                    if (hv[4])
                    begin
                        if (size_reg[SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            phase_next    = PH_ERR;
                            push.valid    = 1'b1;
                            push.res.kind = KIND_ERR;
                        end
                        else
                        begin
                            size_next = {size_reg[SIZE_BITS-5:0], hv[3:0]};
                            saw_next  = 1'b1;
                        end
                    end
                    else if (saw_reg)
                    begin
                        if (s_tdata == CHAR_CR)
                        begin
                            phase_next = PH_LF;
                        end
                        else
                        begin
                            phase_next    = PH_ERR;
                            push.valid    = 1'b1;
                            push.res.kind = KIND_ERR;
                        end
                    end
                    else if (!is_space(s_tdata))
                    begin
                        phase_next    = PH_ERR;
                        push.valid    = 1'b1;
                        push.res.kind = KIND_ERR;
                    end
                end
                PH_LF:
                begin
                    if (s_tdata != CHAR_LF)
                    begin
                        phase_next    = PH_ERR;
                        push.valid    = 1'b1;
                        push.res.kind = KIND_ERR;
                    end
                    else if (size_reg == '0)
                    begin
                        phase_next    = PH_END;
                        push.valid    = 1'b1;
                        push.res.kind = KIND_END;
                    end
                    else
                    begin
                        rem_next   = size_reg;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    rem_next              = rem_reg - 1'b1;
                    push.valid            = 1'b1;
                    push.res.payload_byte = s_tdata;
                    if (rem_reg == SIZE_BITS'(1))
                    begin
                        phase_next = PH_SIZE;
                        size_next  = '0;
                        saw_next   = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            size_reg  <= '0;
            rem_reg   <= '0;
            saw_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            rem_reg   <= rem_next;
            saw_reg   <= saw_next;
        end
    end

    a_err_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR |=> phase_reg == PH_ERR)
        else $error("error state left");

    a_end_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_END |=> phase_reg == PH_END)
        else $error("end state left");

    a_err_push: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && push.res.kind == KIND_ERR |=> phase_reg == PH_ERR)
        else $error("error beat without error state");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_full)
        else $error("push into full queue");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != '0)
        else $error("payload phase with nothing left");

endmodule

### src/hcd_queue.sv
module hcd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcd_pkg::hcd_push_t   push,
    output logic                 q_full,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output hcd_pkg::hcd_result_t head
);
    import hcd_pkg::*;

    hcd_result_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign q_full   = (count_reg == QCNT_W'(QDEPTH));
    assign m_tvalid = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];
    assign do_push  = push.valid && !q_full;
    assign do_pop   = m_tvalid && m_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with pointers apart");

endmodule

### src/http_chunked_decoder_unit.sv
// Channel  Dir  Beat fields (low bit up)              Handshake
// s_axis   in   tdata: in_byte[7:0]                   s_tvalid / s_tready
// m_axis   out  tdata: payload_byte[7:0]              m_tvalid / m_tready
//               tuser: kind[1:0]
// One byte per cycle while s_tready is high; the parser state updates in the cycle the beat is taken.
// Each result is registered into a 4-entry queue and leaves on m_axis from its head, in order.
// s_tready drops only while that queue is full; header bytes give no result but an error or end beat.
// Reset (rst_n low, asynchronous) empties the queue and restarts at the size scan.
module http_chunked_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // payload_byte[7:0]
    output logic [1:0] m_tuser    // kind[1:0]
);
    import hcd_pkg::*;

    hcd_push_t   push;
    hcd_result_t head;
    logic        q_full;

    hcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push)
    );

    hcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .q_full   (q_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = head.payload_byte;
    assign m_tuser = head.kind;

endmodule

### sim/http_chunked_decoder_unit_tb.sv
module http_chunked_decoder_unit_tb;
    import hcd_pkg::*;

    localparam int ITEMS          = 1150;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    class chunk_checker;
        phase_t                phase;
        logic [SIZE_BITS-1:0]  size_accum;
        logic [SIZE_BITS-1:0]  remaining;
        bit                    saw_digit;
        hcd_result_t           decoded_q[$];
        int                    errors;

        function new();
            phase      = PH_SIZE;
            size_accum = '0;
            remaining  = '0;
            saw_digit  = 1'b0;
            errors     = 0;
        endfunction

        function void add_decoded(logic [7:0] data, kind_t kind);
            hcd_result_t r;
            r.payload_byte = data;
            r.kind         = kind;
            decoded_q.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b);
            bit         is_hex;
            logic [3:0] nib;
            is_hex = 1'b1;
            nib    = 4'd0;
            if (b >= "0" && b <= "9")
            begin
                nib = 4'(b - "0");
            end
            else if (b >= "a" && b <= "f")
            begin
                nib = 4'(b - "a" + 8'd10);
            end
            else if (b >= "A" && b <= "F")
            begin
                nib = 4'(b - "A" + 8'd10);
            end
            else
            begin
                is_hex = 1'b0;
            end
            case (phase)
                PH_SIZE:
                begin
                    if (is_hex)
                    begin
                        if (size_accum[SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            phase = PH_ERR;
                            add_decoded(8'h00, KIND_ERR);
                        end
                        else
                        begin
                            size_accum = {size_accum[SIZE_BITS-5:0], nib};
                            saw_digit  = 1'b1;
                        end
                    end
                    else if (saw_digit)
                    begin
                        if (b == CHAR_CR)
                        begin
                            phase = PH_LF;
                        end
                        else
                        begin
                            phase = PH_ERR;
                            add_decoded(8'h00, KIND_ERR);
                        end
                    end
                    else if (!(b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)))
                    begin
                        phase = PH_ERR;
                        add_decoded(8'h00, KIND_ERR);
                    end
                end
                PH_LF:
                begin
                    if (b != CHAR_LF)
                    begin
                        phase = PH_ERR;
                        add_decoded(8'h00, KIND_ERR);
                    end
                    else if (size_accum == '0)
                    begin
                        phase = PH_END;
                        add_decoded(8'h00, KIND_END);
                    end
                    else
                    begin
                        remaining = size_accum;
                        phase     = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    remaining = remaining - 1'b1;
                    if (remaining == '0)
                    begin
                        phase      = PH_SIZE;
                        size_accum = '0;
                        saw_digit  = 1'b0;
                    end
                    add_decoded(b, KIND_DATA);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_beat(logic [7:0] data, logic [1:0] kind);
            hcd_result_t r;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual byte %h kind %0d",
                         $time, data, kind);
                errors++;
                return;
            end
            r = decoded_q.pop_front();
            if (data !== r.payload_byte)
            begin
                $display("%0t: payload_byte mismatch: expected %h, actual %h",
                         $time, r.payload_byte, data);
                errors++;
            end
            if (kind !== r.kind)
            begin
                $display("%0t: kind mismatch: expected %0d, actual %0d",
                         $time, r.kind, kind);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    chunk_checker board;
    int           bytes_sent;
    bit           quiet;
    int           idle_cycles = 0;
    int           stall_left;

    http_chunked_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'("0") + 8'(n);
        end
        return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        board.take_byte(b);
        bytes_sent++;
        if (bytes_sent >= ITEMS - QUIET_TAIL)
        begin
            quiet = 1'b1;
        end
        @(negedge clk);
    endtask

    task automatic send_size_field(input logic [31:0] size, input int zeros);
        int n;
        n = 1;
        while (n < 8 && (size >> (4 * n)) != 0)
        begin
            n++;
        end
        repeat (zeros) send_byte("0");
        for (int i = n - 1; i >= 0; i--)
        begin
            send_byte(hex_char(size[4*i +: 4]));
        end
    endtask

    task automatic send_chunk(input int size);
        logic [7:0] ws_set[6];
        int         zeros;
        ws_set = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, 8'h0B, 8'h0C, CHAR_CR};
        if ($urandom_range(0, 1))
        begin
            send_byte(CHAR_CR);
            send_byte(CHAR_LF);
        end
        repeat ($urandom_range(0, 2)) send_byte(ws_set[$urandom_range(0, 5)]);
        zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        send_size_field(size, zeros);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        repeat (size) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_ending();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0:
            begin
                send_size_field(0, $urandom_range(0, 3));
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            1:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                       (b >= "A" && b <= "F") || b == CHAR_SPACE ||
                       (b >= CHAR_TAB && b <= CHAR_CR));
                send_byte(b);
            end
            2:
            begin
                send_size_field($urandom_range(0, 300), $urandom_range(0, 2));
                do
                    b = 8'($urandom_range(0, 255));
                while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                       (b >= "A" && b <= "F") || b == CHAR_CR);
                send_byte(b);
            end
            3:
            begin
                send_size_field($urandom_range(0, 300), $urandom_range(0, 2));
                send_byte(CHAR_CR);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CHAR_LF);
                send_byte(b);
            end
            default:
            begin
                send_byte(hex_char(4'($urandom_range(1, 15))));
                repeat (8) send_byte(hex_char(4'($urandom_range(0, 15))));
            end
        endcase
    endtask

    initial
    begin
        logic [7:0] opening[19];
        int         size;
        board    = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        bytes_sent = 0;
        quiet      = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        opening = '{CHAR_SPACE, CHAR_TAB, 8'h0B, 8'h0C, CHAR_CR, CHAR_LF,
                    "0", "0", "3", CHAR_CR, CHAR_LF, 8'h00, 8'hFF, CHAR_CR,
                    "2", CHAR_CR, CHAR_LF, CHAR_LF, "z"};
        foreach (opening[i])
        begin
            send_byte(opening[i]);
        end

        while (bytes_sent < ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: size = $urandom_range(9, 40);
                3:       size = $urandom_range(41, 160);
                default: size = $urandom_range(1, 8);
            endcase
            send_chunk(size);
        end
        send_ending();
        repeat ($urandom_range(8, 20)) send_byte(8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        while (board.decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_beat(m_tdata, m_tuser);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

### http_chunked_decoder_unit.f
src/hcd_pkg.sv
src/hcd_front.sv
src/hcd_queue.sv
src/http_chunked_decoder_unit.sv
sim/http_chunked_decoder_unit_tb.sv
